### hdl/assert_macros.svh
// Assertion macros used by the RTL of the hash set block.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with a reset that disables it.
`define HSG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion on the block's own clock and reset.
`define HSG_ASSERT_CLK(lbl, prop, msg) \
   `HSG_ASSERT(lbl, clock, reset, prop, msg)

`endif

### hdl/hsg_pkg.sv
// Shared constants, types and helpers for the linear probing hash set.
// No dependencies; imported by every module of the block.
package hsg_pkg;

   localparam int SLOTS_DEFAULT = 1024;
   localparam int FIELD_W = 11;
   localparam int KEY_W = 64;
   localparam int SLOT_W = 10;
   localparam int OP_W = 3;
   localparam int STAT_W = 3;
   localparam int CW = 17;
   localparam int DIV_W = 16;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [FIELD_W-1:0] FIELD_MAX = 11'd2047;

   localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
   localparam logic [OP_W-1:0] OP_FIND_EMPTY = 3'd3;
   localparam logic [OP_W-1:0] OP_READ_REACH = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK = 3'd0;
   localparam logic [STAT_W-1:0] STAT_DUPLICATE = 3'd1;
   localparam logic [STAT_W-1:0] STAT_FULL = 3'd2;
   localparam logic [STAT_W-1:0] STAT_ABSENT = 3'd3;
   localparam logic [STAT_W-1:0] STAT_NO_EMPTY = 3'd4;

   localparam logic CSR_IDX_PERIOD = 1'b0;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_GRAVE,
      ST_PROBE_RD,
      ST_PROBE_EV,
      ST_REACH_RD,
      ST_REACH_WR,
      ST_RREAD_RD,
      ST_RREAD_EV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic meta_we;
      logic key_we;
   } tbl_wr_type;

   function automatic logic [FIELD_W-1:0] sat_field(input logic [CW-1:0] v);
      logic [FIELD_W-1:0] r;
      r = (v > CW'(FIELD_MAX)) ? FIELD_MAX : v[FIELD_W-1:0];
      return r;
   endfunction

endpackage

### hdl/hsg_rem.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on hsg_pkg; works out the graveyard phase of the home slot.
module hsg_rem import hsg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [CW-1:0]     divisor,
   output logic              done,
   output logic [CW-1:0]     remainder
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [DIV_W-1:0] dvd_ff, dvd_in;
   logic [CW-1:0]    dvs_ff, dvs_in;
   logic [CW-1:0]    rem_ff, rem_in;
   logic [CW-1:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      // The partial remainder stays below the divisor, so its top bit is free.
      trial = {rem_ff[CW-2:0], dvd_ff[DIV_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         dvd_in = dividend;
         dvs_in = divisor;
         rem_in = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         rem_in = (trial >= dvs_ff) ? (trial - dvs_ff) : trial;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign remainder = rem_ff;

endmodule

### hdl/hsg_table.sv
// Slot storage: a metadata memory (used flag and reach) and a key memory.
// Depends on hsg_pkg; one write port and one registered read port each.
module hsg_table import hsg_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT,
   localparam int IW = $clog2(SLOTS)
) (
   input  logic               clock,
   input  tbl_wr_type         wr,
   input  logic [IW-1:0]      waddr,
   input  logic               wused,
   input  logic [FIELD_W-1:0] wreach,
   input  logic [KEY_W-1:0]   wkey,
   input  logic [IW-1:0]      raddr,
   output logic               rused,
   output logic [FIELD_W-1:0] rreach,
   output logic [KEY_W-1:0]   rkey
);

   logic [FIELD_W:0]   meta_mem [SLOTS];
   logic [KEY_W-1:0]   key_mem [SLOTS];
   logic [FIELD_W:0]   meta_rd_ff;
   logic [KEY_W-1:0]   key_rd_ff;

   always_ff @(posedge clock) begin
      if (wr.meta_we) begin
         meta_mem[waddr] <= {wused, wreach};
      end
      meta_rd_ff <= meta_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (wr.key_we) begin
         key_mem[waddr] <= wkey;
      end
      key_rd_ff <= key_mem[raddr];
   end

   assign rused = meta_rd_ff[FIELD_W];
   assign rreach = meta_rd_ff[FIELD_W-1:0];
   assign rkey = key_rd_ff;

endmodule

### hdl/linear_probe_hash_set_graveyard_core.sv
// Linear probing hash set with graveyard slots; one operation is worked on at a time.
// Each probe reads a slot and evaluates it; an insert that fills a slot then reads and
// updates its home slot's reach, a skipping insert first works out its graveyard phase,
// a reach read reads the home slot, an unused opcode goes straight to posting. A new request
// is taken only once the result is posted, in the cycle it appears. Reset and clear run a
// clearing pass over every metadata slot, taking no item meanwhile; keys are left as they are.
`include "assert_macros.svh"
module linear_probe_hash_set_graveyard_core import hsg_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [OP_W-1:0]    req_opcode,
   input  logic [KEY_W-1:0]   req_key,
   input  logic [SLOT_W-1:0]  req_slot,
   input  logic               req_skip_graveyard,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [FIELD_W-1:0] rsp_probe_length,
   output logic [FIELD_W-1:0] rsp_occupied_count,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [CSR_DW-1:0]  csr_pwdata,
   output logic [CSR_DW-1:0]  csr_prdata,
   output logic               csr_pready
);

   localparam int IW = $clog2(SLOTS);
   localparam int OW = $clog2(SLOTS + 1);
   localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
   localparam int RSH = 20;
   localparam int PW = SLOT_W + RSH;
   localparam int MW = 2 * SLOT_W;
   localparam int RECIP = (2 ** RSH + SLOTS - 1) / SLOTS;

   state_type state_ff, state_in;

   logic [OP_W-1:0]    op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic               gmode_ff, gmode_in;
   logic               clr_rsp_ff, clr_rsp_in;
   logic [IW-1:0]      home_ff, home_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [IW-1:0]      off_ff, off_in;
   logic [IW-1:0]      cidx_ff, cidx_in;
   logic [FIELD_W-1:0] grem_ff, grem_in;
   logic [OW-1:0]      occ_ff, occ_in;
   logic [STAT_W-1:0]  res_status_ff, res_status_in;
   logic [FIELD_W-1:0] res_plen_ff, res_plen_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [FIELD_W-1:0] rsp_plen_ff, rsp_plen_in;
   logic [FIELD_W-1:0] rsp_occ_ff, rsp_occ_in;
   logic [FIELD_W-1:0] period_ff, period_in;

   logic               accept;
   logic               op_used;
   logic               grave_req;
   logic               rsp_free;
   logic               last_probe;
   logic               grave_slot;
   logic               found;
   logic [CW-1:0]      plen_next;
   logic [FIELD_W-1:0] plen_sat;
   logic [IW-1:0]      idx_next;
   logic [FIELD_W-1:0] grem_next;
   logic [FIELD_W-1:0] grem_inc;
   logic [PW-1:0]      hprod;
   logic [MW-1:0]      hmul;
   logic [IW-1:0]      home_calc;

   logic               rem_start;
   logic [DIV_W-1:0]   rem_dividend;
   logic [CW-1:0]      rem_divisor;
   logic               rem_done;
   logic [CW-1:0]      rem_value;

   tbl_wr_type         tbl_wr;
   logic [IW-1:0]      tbl_waddr;
   logic               tbl_wused;
   logic [FIELD_W-1:0] tbl_wreach;
   logic [IW-1:0]      tbl_raddr;
   logic               tbl_rused;
   logic [FIELD_W-1:0] tbl_rreach;
   logic [KEY_W-1:0]   tbl_rkey;
   logic               csr_write;

   hsg_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rem_dividend),
      .divisor   (rem_divisor),
      .done      (rem_done),
      .remainder (rem_value)
   );

   hsg_table #(.SLOTS(SLOTS)) u_table (
      .clock  (clock),
      .wr     (tbl_wr),
      .waddr  (tbl_waddr),
      .wused  (tbl_wused),
      .wreach (tbl_wreach),
      .wkey   (key_ff),
      .raddr  (tbl_raddr),
      .rused  (tbl_rused),
      .rreach (tbl_rreach),
      .rkey   (tbl_rkey)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign op_used = (req_opcode == OP_INSERT) || (req_opcode == OP_LOOKUP) ||
                    (req_opcode == OP_FIND_EMPTY) || (req_opcode == OP_READ_REACH);
   assign grave_req = (req_opcode == OP_INSERT) && req_skip_graveyard && (period_ff != '0);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // The home slot is the requested slot reduced modulo SLOTS by a reciprocal
   // multiplication, which is exact for every ten-bit slot.
   assign hprod = PW'(req_slot) * PW'(RECIP);
   assign hmul = MW'(hprod[PW-1:RSH]) * MW'(SLOTS);
   assign home_calc = (SLOTS >= (1 << SLOT_W)) ? IW'(req_slot)
                                               : IW'(req_slot - hmul[SLOT_W-1:0]);

   assign last_probe = (off_ff == LAST);
   assign plen_next = CW'(off_ff) + CW'(1);
   assign plen_sat = sat_field(plen_next);
   assign idx_next = (idx_ff == LAST) ? '0 : (idx_ff + IW'(1));
   assign grem_inc = grem_ff + FIELD_W'(1);
   // The graveyard phase restarts at zero where the index wraps round to slot zero.
   assign grem_next = (idx_ff == LAST || grem_inc == period_ff) ? '0 : grem_inc;
   assign grave_slot = gmode_ff && (grem_ff == '0);
   assign found = tbl_rused && (tbl_rkey == key_ff);

   assign rem_start = accept && grave_req;
   assign rem_dividend = DIV_W'(home_calc);
   assign rem_divisor = CW'(period_ff);

   assign tbl_raddr = (state_ff == ST_REACH_RD || state_ff == ST_RREAD_RD) ? home_ff : idx_ff;

   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_PERIOD) ? CSR_DW'(period_ff) : '0;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (cidx_ff == LAST) begin
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_CLEAR) begin
                  state_in = ST_CLEAR;
               end else if (grave_req) begin
                  state_in = ST_GRAVE;
               end else if (req_opcode == OP_READ_REACH) begin
                  state_in = ST_RREAD_RD;
               end else if (op_used) begin
                  state_in = ST_PROBE_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_GRAVE: begin
            if (rem_done) begin
               state_in = ST_PROBE_RD;
            end
         end
         ST_PROBE_RD: state_in = ST_PROBE_EV;
         ST_PROBE_EV: begin
            if (op_ff == OP_INSERT && !grave_slot && !tbl_rused) begin
               state_in = ST_REACH_RD;
            end else if ((op_ff == OP_INSERT && !grave_slot && found) ||
                         (op_ff == OP_LOOKUP && found) ||
                         (op_ff == OP_FIND_EMPTY && !tbl_rused) || last_probe) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_PROBE_RD;
            end
         end
         ST_REACH_RD: state_in = ST_REACH_WR;
         ST_REACH_WR: state_in = ST_DONE;
         ST_RREAD_RD: state_in = ST_RREAD_EV;
         ST_RREAD_EV: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      op_in = op_ff;
      key_in = key_ff;
      gmode_in = gmode_ff;
      clr_rsp_in = clr_rsp_ff;
      home_in = home_ff;
      idx_in = idx_ff;
      off_in = off_ff;
      cidx_in = cidx_ff;
      grem_in = grem_ff;
      occ_in = occ_ff;
      res_status_in = res_status_ff;
      res_plen_in = res_plen_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_plen_in = rsp_plen_ff;
      rsp_occ_in = rsp_occ_ff;
      period_in = period_ff;
      tbl_wr = '0;
      tbl_waddr = idx_ff;
      tbl_wused = 1'b1;
      tbl_wreach = tbl_rreach;

      if (csr_write && csr_pready && csr_paddr[2] == CSR_IDX_PERIOD) begin
         period_in = csr_pwdata[FIELD_W-1:0];
      end

      unique case (state_ff)
         ST_CLEAR: begin
            tbl_wr.meta_we = 1'b1;
            tbl_waddr = cidx_ff;
            tbl_wused = 1'b0;
            tbl_wreach = '0;
            cidx_in = cidx_ff + IW'(1);
            if (cidx_ff == LAST) begin
               cidx_in = '0;
               occ_in = '0;
               res_status_in = STAT_OK;
               res_plen_in = '0;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in = req_opcode;
               key_in = req_key;
               clr_rsp_in = (req_opcode == OP_CLEAR);
               cidx_in = '0;
               home_in = home_calc;
               idx_in = home_calc;
               off_in = '0;
               gmode_in = grave_req;
               res_status_in = STAT_OK;
               res_plen_in = '0;
            end
         end
         ST_GRAVE: begin
            if (rem_done) begin
               grem_in = rem_value[FIELD_W-1:0];
            end
         end
         ST_PROBE_RD: begin
         end
         ST_PROBE_EV: begin
            if (op_ff == OP_INSERT && !grave_slot && !tbl_rused) begin
               tbl_wr.meta_we = 1'b1;
               tbl_wr.key_we = 1'b1;
               occ_in = occ_ff + OW'(1);
               res_status_in = STAT_OK;
               res_plen_in = plen_sat;
            end else if ((op_ff == OP_INSERT && !grave_slot && found) ||
                         (op_ff == OP_LOOKUP && found) ||
                         (op_ff == OP_FIND_EMPTY && !tbl_rused)) begin
               res_status_in = (op_ff == OP_INSERT) ? STAT_DUPLICATE : STAT_OK;
               res_plen_in = plen_sat;
            end else if (last_probe) begin
               case (op_ff)
                  OP_INSERT: begin
                     res_status_in = STAT_FULL;
                     res_plen_in = sat_field(CW'(SLOTS));
                  end
                  OP_LOOKUP: begin
                     res_status_in = STAT_ABSENT;
                     res_plen_in = '0;
                  end
                  default: begin
                     res_status_in = STAT_NO_EMPTY;
                     res_plen_in = '0;
                  end
               endcase
            end else begin
               off_in = off_ff + IW'(1);
               idx_in = idx_next;
               grem_in = grem_next;
            end
         end
         ST_REACH_RD: begin
         end
         ST_REACH_WR: begin
            // The home entry was read after the new slot was written, so its flag is current.
            if (plen_sat > tbl_rreach) begin
               tbl_wr.meta_we = 1'b1;
               tbl_waddr = home_ff;
               tbl_wused = tbl_rused;
               tbl_wreach = plen_sat;
            end
         end
         ST_RREAD_RD: begin
         end
         ST_RREAD_EV: begin
            res_status_in = STAT_OK;
            res_plen_in = tbl_rreach;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_plen_in = res_plen_ff;
               rsp_occ_in = sat_field(CW'(occ_ff));
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cidx_ff <= '0;
         occ_ff <= '0;
         clr_rsp_ff <= 1'b0;
         gmode_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         period_ff <= '0;
      end else begin
         state_ff <= state_in;
         cidx_ff <= cidx_in;
         occ_ff <= occ_in;
         clr_rsp_ff <= clr_rsp_in;
         gmode_ff <= gmode_in;
         rsp_valid_ff <= rsp_valid_in;
         period_ff <= period_in;
      end
      op_ff <= op_in;
      key_ff <= key_in;
      home_ff <= home_in;
      idx_ff <= idx_in;
      off_ff <= off_in;
      grem_ff <= grem_in;
      res_status_ff <= res_status_in;
      res_plen_ff <= res_plen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_plen_ff <= rsp_plen_in;
      rsp_occ_ff <= rsp_occ_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_probe_length = rsp_plen_ff;
   assign rsp_occupied_count = rsp_occ_ff;

   `HSG_ASSERT_CLK(a_occ_bound, occ_ff <= OW'(SLOTS), "occupied count exceeds table size")
   `HSG_ASSERT_CLK(a_full_len, (rsp_valid && rsp_status == STAT_FULL) |-> (rsp_probe_length == sat_field(CW'(SLOTS))), "full result with wrong probe length")
   `HSG_ASSERT_CLK(a_miss_len, (rsp_valid && (rsp_status == STAT_ABSENT || rsp_status == STAT_NO_EMPTY)) |-> (rsp_probe_length == '0), "miss result with nonzero length")
   `HSG_ASSERT_CLK(a_probe_seq, (state_ff == ST_PROBE_EV) |-> ($past(state_ff) == ST_PROBE_RD), "probe evaluated without a read")

endmodule

### tb/hsg_checker.sv
// Checker for the linear probing hash set: watches both channels and the register port,
// predicts every result from its own copy of the table and compares field by field.
// Depends on hsg_pkg; instantiated beside the block by the testbench top.
module hsg_checker import hsg_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [OP_W-1:0]    req_opcode,
   input  logic [KEY_W-1:0]   req_key,
   input  logic [SLOT_W-1:0]  req_slot,
   input  logic               req_skip_graveyard,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [STAT_W-1:0]  rsp_status,
   input  logic [FIELD_W-1:0] rsp_probe_length,
   input  logic [FIELD_W-1:0] rsp_occupied_count,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic               csr_pready,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [CSR_DW-1:0]  csr_pwdata,
   output int                 fail_count,
   output int                 pending,
   output int                 results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [STAT_W-1:0]  status;
      logic [FIELD_W-1:0] probe_length;
      logic [FIELD_W-1:0] occupied_count;
   } outcome_type;

   bit                 used_tbl [SLOTS];
   logic [KEY_W-1:0]   key_tbl [SLOTS];
   logic [FIELD_W-1:0] reach_tbl [SLOTS];
   int                 occupancy;
   int                 period;
   outcome_type        outcomes [$];

   assign pending = outcomes.size();

   function automatic logic [FIELD_W-1:0] clip(input int v);
      return (v > int'(FIELD_MAX)) ? FIELD_MAX : FIELD_W'(v);
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   task automatic wipe_table();
      for (int i = 0; i < SLOTS; i++) begin
         used_tbl[i] = 1'b0;
         reach_tbl[i] = '0;
      end
      occupancy = 0;
   endtask

   // Works out the outcome of one operation and applies it to the table copy.
   task automatic hash_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                          input logic [SLOT_W-1:0] slot, input logic skip);
      outcome_type o;
      int          home;
      int          idx;
      int          plen;
      home = int'(slot) % SLOTS;
      idx = home;
      plen = 0;
      o.status = STAT_OK;
      case (op)
         OP_CLEAR: wipe_table();
         OP_INSERT: begin
            o.status = STAT_FULL;
            plen = SLOTS;
            for (int off = 0; off < SLOTS; off++) begin
               if (!(skip && period != 0 && idx % period == 0)) begin
                  if (!used_tbl[idx]) begin
                     used_tbl[idx] = 1'b1;
                     key_tbl[idx] = key;
                     occupancy++;
                     if (clip(off + 1) > reach_tbl[home]) reach_tbl[home] = clip(off + 1);
                     o.status = STAT_OK;
                     plen = off + 1;
                     break;
                  end
                  if (key_tbl[idx] == key) begin
                     o.status = STAT_DUPLICATE;
                     plen = off + 1;
                     break;
                  end
               end
               idx = (idx + 1) % SLOTS;
            end
         end
         OP_LOOKUP: begin
            o.status = STAT_ABSENT;
            for (int off = 0; off < SLOTS; off++) begin
               if (used_tbl[idx] && key_tbl[idx] == key) begin
                  o.status = STAT_OK;
                  plen = off + 1;
                  break;
               end
               idx = (idx + 1) % SLOTS;
            end
         end
         OP_FIND_EMPTY: begin
            o.status = STAT_NO_EMPTY;
            for (int off = 0; off < SLOTS; off++) begin
               if (!used_tbl[idx]) begin
                  o.status = STAT_OK;
                  plen = off + 1;
                  break;
               end
               idx = (idx + 1) % SLOTS;
            end
         end
         OP_READ_REACH: plen = int'(reach_tbl[home]);
         default: ;
      endcase
      o.probe_length = clip(plen);
      o.occupied_count = clip(occupancy);
      outcomes = {outcomes, o};
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         wipe_table();
         period = 0;
         outcomes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (outcomes.size() == 0) begin
               report_mismatch("result transfer with no result expected");
            end else begin
               want = outcomes.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               if (rsp_probe_length !== want.probe_length)
                  report_mismatch($sformatf("probe_length %0d, expected %0d",
                                            rsp_probe_length, want.probe_length));
               if (rsp_occupied_count !== want.occupied_count)
                  report_mismatch($sformatf("occupied_count %0d, expected %0d",
                                            rsp_occupied_count, want.occupied_count));
            end
         end
         if (req_valid && !req_stall)
            hash_op(req_opcode, req_key, req_slot, req_skip_graveyard);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == CSR_AW'(4 * CSR_IDX_PERIOD))
            period = int'(csr_pwdata[FIELD_W-1:0]);
      end
   end

   initial begin
      fail_count = 0;
      results_seen = 0;
      period = 0;
      occupancy = 0;
   end

endmodule

### tb/tb_linear_probe_hash_set_graveyard_core.sv
// Testbench top for the linear probing hash set: clock, reset, stimulus and verdict.
// Depends on hsg_pkg, the block itself and hsg_checker, which does all the checking.
module tb_linear_probe_hash_set_graveyard_core import hsg_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = SLOTS_DEFAULT;
   localparam logic [OP_W-1:0] OP_SPARE_FIRST = OP_READ_REACH + 3'd1;
   localparam logic [OP_W-1:0] OP_SPARE_LAST = '1;
   localparam int POOL_N = 48;
   localparam int RANDOM_ITEMS = 24;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [OP_W-1:0]    req_opcode = OP_CLEAR;
   logic [KEY_W-1:0]   req_key = '0;
   logic [SLOT_W-1:0]  req_slot = '0;
   logic               req_skip_graveyard = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [STAT_W-1:0]  rsp_status;
   logic [FIELD_W-1:0] rsp_probe_length;
   logic [FIELD_W-1:0] rsp_occupied_count;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]  csr_paddr = '0;
   logic [CSR_DW-1:0]  csr_pwdata = '0;
   logic [CSR_DW-1:0]  csr_prdata;
   logic               csr_pready;

   int                 fail_count;
   int                 pending;
   int                 results_seen;
   int                 items_sent = 0;
   int                 burst_left = 0;
   int                 inserts_since_clear = 0;
   bit                 hold_request = 1'b0;
   bit                 random_idling = 1'b0;
   logic [KEY_W-1:0]   key_pool [POOL_N];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   linear_probe_hash_set_graveyard_core #(.SLOTS(SLOTS)) dut (.*);

   hsg_checker #(.SLOTS(SLOTS)) checker_i (.*);

   // One transfer on the request channel; in random mode the sender may idle between bursts.
   task automatic send(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                       input logic [SLOT_W-1:0] slot, input logic skip);
      if (random_idling && burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_key <= key;
      req_slot <= slot;
      req_skip_graveyard <= skip;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (burst_left > 0) burst_left--;
      if (op == OP_CLEAR) inserts_since_clear = 0;
      if (op == OP_INSERT) inserts_since_clear++;
   endtask

   // Registers change only when the block is idle; the wait covers a clearing pass.
   task automatic set_period(input int p);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SLOTS + 100) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'(4 * CSR_IDX_PERIOD);
      csr_pwdata <= CSR_DW'(p);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic logic [OP_W-1:0] OP_OP_SPARE_PICK();
      return OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
   endfunction

   task automatic random_item();
      int               r;
      logic [KEY_W-1:0] key;
      logic [SLOT_W-1:0] slot;
      logic [OP_W-1:0]  op;
      r = $urandom_range(0, 99);
      if (r < 2 || inserts_since_clear > 500) op = OP_CLEAR;
      else if (r < 50) op = OP_INSERT;
      else if (r < 68) op = OP_LOOKUP;
      else if (r < 80) op = OP_FIND_EMPTY;
      else if (r < 94) op = OP_READ_REACH;
      else op = OP_OP_SPARE_PICK();
      key = ($urandom_range(0, 9) < 6) ? key_pool[$urandom_range(0, POOL_N - 1)]
                                        : {$urandom, $urandom};
      // Half the traffic lands in a narrow window so clusters form, some across the wrap.
      if ($urandom_range(0, 1)) slot = SLOT_W'(SLOTS - 8 + $urandom_range(0, 15));
      else slot = SLOT_W'($urandom);
      send(op, key, slot, 1'($urandom_range(0, 1)));
   endtask

   // Receiver: stall pattern switches at random among three modes, plus one long hold.
   initial begin
      int mode;
      int left;
      mode = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (3000) @(posedge clock);
            hold_request = 1'b0;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 2);
            left = $urandom_range(50, 300);
         end
         left--;
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 30);
            default: rsp_stall <= ($urandom_range(0, 99) < 75);
         endcase
      end
   end

   initial begin
      int periods [4];
      periods = '{2, 3, 7, 0};
      periods[3] = $urandom_range(4, SLOTS);
      for (int i = 0; i < POOL_N; i++) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Graveyards off: key and slot extremes, wraparound, every operation.
      set_period(0);
      send(OP_INSERT, '0, '0, 1'b0);
      send(OP_INSERT, '1, '1, 1'b1);
      send(OP_INSERT, 64'h5, '1, 1'b0);
      send(OP_INSERT, '1, '1, 1'b0);
      send(OP_LOOKUP, '1, '1, 1'b0);
      send(OP_LOOKUP, 64'h5, '1, 1'b0);
      send(OP_LOOKUP, 64'hA5A5_5A5A_F00D_1234, 10'd3, 1'b0);
      send(OP_FIND_EMPTY, 64'h0, '1, 1'b0);
      send(OP_READ_REACH, '0, '1, 1'b0);
      send(OP_READ_REACH, '0, '0, 1'b1);
      send(OP_SPARE_FIRST, '1, '1, 1'b1);
      send(OP_SPARE_LAST, 64'h1234, 10'd9, 1'b0);
      send(OP_CLEAR, '1, '1, 1'b1);
      send(OP_READ_REACH, '0, '1, 1'b0);

      // Every slot a graveyard: a skipping insert finds the table full.
      set_period(1);
      send(OP_INSERT, 64'h77, 10'd10, 1'b1);
      send(OP_INSERT, 64'h77, 10'd10, 1'b0);
      send(OP_INSERT, 64'h77, 10'd10, 1'b1);

      // A key sitting in a graveyard slot is invisible to a skipping insert.
      set_period(SLOTS);
      send(OP_INSERT, 64'h99, '0, 1'b0);
      send(OP_INSERT, 64'h99, '0, 1'b1);
      send(OP_READ_REACH, '0, '0, 1'b0);

      // Fill the whole table, then probe it when it has no room left.
      send(OP_CLEAR, '0, '0, 1'b0);
      for (int i = 0; i < SLOTS; i++)
         send(OP_INSERT, KEY_W'(i) ^ key_pool[2], SLOT_W'(i), 1'b0);
      send(OP_INSERT, key_pool[3], 10'd500, 1'b0);
      send(OP_INSERT, key_pool[2], '0, 1'b0);
      send(OP_FIND_EMPTY, '0, 10'd77, 1'b0);
      send(OP_LOOKUP, ~key_pool[2], 10'd1, 1'b0);
      send(OP_INSERT, key_pool[3], 10'd4, 1'b1);
      send(OP_CLEAR, '0, '0, 1'b0);

      random_idling = 1'b1;
      foreach (periods[p]) begin
         set_period(periods[p]);
         send(OP_CLEAR, '0, '0, 1'b0);
         if (p == 0) hold_request = 1'b1;
         for (int i = 0; i < RANDOM_ITEMS; i++) random_item();
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SLOTS + 200) @(posedge clock);
      $display("Run covered %0d request transfers and %0d result transfers", items_sent,
               results_seen);
      $display("over graveyard periods 0, 1, %0d and four random phases.", SLOTS);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("Timed out with %0d results outstanding.", pending);
      $display("== FAIL ==");
      $finish;
   end

endmodule
